/* design/bbem_pkg.sv */
// Shared types and constants for the 3x3 edge-mean box blur.
`timescale 1ns / 1ps

package bbem_pkg;

    // Default geometry limits handed to the top-level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0]     CFG_RESET        = 11'd1024;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Pixel layout: red in the lowest byte, alpha in the highest
    localparam int PIX_W     = 32;
    localparam int CH_RED    = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 2;
    localparam int CH_ALPHA  = 3;
    localparam int NUM_COLOR = 3;
    localparam int SUM_W     = 12;

    typedef logic [3:0][7:0] pixel_t;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    // Which neighbors take part in one output, decided by the front
    typedef struct packed {
        logic emit;
        logic use_left;
        logic use_right;
        logic use_top;
        logic use_bottom;
        logic last;
    } flags_t;

    // One new window column: the pixel two rows up, one row up, and current
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        flags_t  flags;
        column_t column;
    } entry_t;

    // Line store word: both earlier rows at one column
    typedef struct packed {
        pixel_t two_above;
        pixel_t above;
    } line_word_t;

    // Divisor for the number of in-frame neighbors
    typedef enum logic [1:0] {
        DIV_BY_4 = 2'd0,
        DIV_BY_6 = 2'd1,
        DIV_BY_9 = 2'd2
    } div_sel_t;

endpackage

/* design/box_blur_3x3_edge_mean.sv */
// Top level of the 3x3 edge-mean box blur over an RGBA pixel stream.
//
// Usage:
//   Slave channel (s_*): one RGBA word per handshake in raster order; tuser
//   set to 1 marks a drain word. Master channel (m_*): one blurred pixel per
//   handshake, tlast high on the final pixel of the frame.
//   Write image_width (index 0) and image_height (index 1) on the cfg port
//   while idle; any write restarts the frame. Values clamp to 2..MAX_*.
//   Each output pixel belongs to the word one row plus one pixel earlier;
//   after the last pixel send width+1 drain words to flush the frame.
//   Drain words sent before the frame is complete are dropped.
// Timing:
//   One word per cycle sustained unless back pressure fills the queue. A
//   result passes line store read, queue, sum stage and divide stage on its
//   way to m_tvalid. The line store is one read and one write port per cycle.
// Reset:
//   rst_n clears position, pipeline and queue and loads 1024x1024; the line
//   stores hold garbage, which only ever feeds neighbors outside the frame.
// Back pressure:
//   When m_tready is low, the output register and sum stage hold, the
//   4-entry queue fills, and s_tready drops once no room is left.
`timescale 1ns / 1ps

module box_blur_3x3_edge_mean #(
    parameter int MAX_WIDTH  = bbem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // in_red[7:0], in_green[15:8], in_blue[23:16], in_alpha[31:24]
    input  logic [bbem_pkg::PIX_W-1:0]        s_tdata,
    // command[0]: 0 pixel, 1 drain
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [bbem_pkg::PIX_W-1:0]        m_tdata,
    // last_in_frame
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [bbem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bbem_pkg::CFG_W-1:0]        cfg_data
);

    logic                                  push;
    bbem_pkg::entry_t                      push_entry;
    logic                                  pop;
    logic                                  q_valid;
    bbem_pkg::entry_t                      q_head;
    logic [bbem_pkg::QUEUE_LEVEL_W-1:0]    q_level;

    // Front: track the raster position, classify each word, read and
    // rewrite the two line stores, then push one window column per word.
    bbem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .command    (s_tuser[0]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_level    (q_level),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: absorb back-end stalls so the front keeps taking words
    bbem_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .valid      (q_valid),
        .head       (q_head),
        .level      (q_level)
    );

    // Back: advance the column window, sum in-frame neighbors, divide,
    // and hold the result in the output register until taken.
    bbem_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/bbem_front.sv */
// Front end: raster position, word classification and the two line stores.
`timescale 1ns / 1ps

module bbem_front #(
    parameter int MAX_WIDTH  = bbem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bbem_pkg::PIX_W-1:0]           s_tdata,
    input  logic                                 command,
    input  logic                                 cfg_we,
    input  logic [bbem_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bbem_pkg::CFG_W-1:0]           cfg_data,
    input  logic [bbem_pkg::QUEUE_LEVEL_W-1:0]   q_level,
    output logic                                 push,
    output bbem_pkg::entry_t                     push_entry
);

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [bbem_pkg::CFG_W-1:0] width_cfg_reg;
    logic [bbem_pkg::CFG_W-1:0] height_cfg_reg;
    logic [WW-1:0]              eff_w;
    logic [RW-1:0]              eff_h;
    logic [CW-1:0]              w_last;

    logic [CW-1:0]              ic_reg;
    logic [CW-1:0]              ic_next;
    logic [RW-1:0]              ir_reg;
    logic [RW-1:0]              ir_next;

    logic                       accept;
    logic                       draining;
    logic                       take;
    logic                       at_col0;
    bbem_pkg::flags_t           flags;
    bbem_pkg::pixel_t           px;

    logic                       f1_valid_reg;
    logic [CW-1:0]              f1_ic_reg;
    bbem_pkg::pixel_t           f1_px_reg;
    bbem_pkg::flags_t           f1_flags_reg;

    bbem_pkg::line_word_t       line_mem [MAX_WIDTH];
    bbem_pkg::line_word_t       rd_reg;
    bbem_pkg::line_word_t       wr_word;

    // Clamp the programmed geometry to the supported range
    always_comb
    begin
        if (width_cfg_reg < 11'd2)
            eff_w = WW'(2);
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_cfg_reg);

        if (height_cfg_reg < 11'd2)
            eff_h = RW'(2);
        else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(height_cfg_reg);

        w_last = CW'(eff_w - WW'(1));
    end

    assign s_tready = (32'(q_level) + 32'(f1_valid_reg)) < bbem_pkg::QUEUE_DEPTH;
    assign accept   = s_tvalid && s_tready;
    assign draining = ir_reg >= eff_h;
    // a drain word before the frame is complete is dropped
    assign take     = accept && !(command && !draining);
    assign at_col0  = (ic_reg == '0);
    assign px       = draining ? bbem_pkg::pixel_t'('0) : bbem_pkg::pixel_t'(s_tdata);

    // Classify: row start finishes the last column of the row two above,
    // any other column finishes the previous pixel of the row above.
    always_comb
    begin
        if (at_col0)
        begin
            flags.emit       = ir_reg >= RW'(2);
            flags.use_left   = 1'b1;
            flags.use_right  = 1'b0;
            flags.use_top    = ir_reg != RW'(2);
            flags.use_bottom = ir_reg <= eff_h;
            flags.last       = ir_reg == RW'(eff_h + RW'(1));
        end
        else
        begin
            flags.emit       = ir_reg >= RW'(1);
            flags.use_left   = ic_reg != CW'(1);
            flags.use_right  = 1'b1;
            flags.use_top    = ir_reg != RW'(1);
            flags.use_bottom = ir_reg < eff_h;
            flags.last       = 1'b0;
        end
    end

    always_comb
    begin
        ic_next = ic_reg;
        ir_next = ir_reg;
        if (cfg_we)
        begin
            ic_next = '0;
            ir_next = '0;
        end
        else if (take)
        begin
            if (flags.last)
            begin
                ic_next = '0;
                ir_next = '0;
            end
            else if (ic_reg == w_last)
            begin
                ic_next = '0;
                ir_next = ir_reg + RW'(1);
            end
            else
            begin
                ic_next = ic_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= bbem_pkg::CFG_RESET;
            height_cfg_reg <= bbem_pkg::CFG_RESET;
            ic_reg         <= '0;
            ir_reg         <= '0;
            f1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bbem_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    bbem_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            ic_reg       <= ic_next;
            ir_reg       <= ir_next;
            f1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f1_ic_reg    <= ic_reg;
            f1_px_reg    <= px;
            f1_flags_reg <= flags;
        end
    end

    // Shift the column down one row in the store: above moves to two-above
    assign wr_word.two_above = rd_reg.above;
    assign wr_word.above     = f1_px_reg;

    always_ff @(posedge clk)
    begin
        if (f1_valid_reg)
            line_mem[f1_ic_reg] <= wr_word;
        if (take)
        begin
            // forward a write still in flight to the same column
            if (f1_valid_reg && (f1_ic_reg == ic_reg))
                rd_reg <= wr_word;
            else
                rd_reg <= line_mem[ic_reg];
        end
    end

    assign push                     = f1_valid_reg;
    assign push_entry.flags         = f1_flags_reg;
    assign push_entry.column.top    = rd_reg.two_above;
    assign push_entry.column.mid    = rd_reg.above;
    assign push_entry.column.bot    = f1_px_reg;

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && flags.last) |=> (ir_reg == '0 && ic_reg == '0))
        else $error("frame did not restart after its final output");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ic_reg) < 32'(eff_w))
        else $error("column position beyond row width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ir_reg) <= 32'(eff_h) + 1)
        else $error("row position beyond drain row");
`endif

endmodule

/* design/bbem_queue.sv */
// Short FIFO between the front end and the averaging back end.
`timescale 1ns / 1ps

module bbem_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  bbem_pkg::entry_t                    push_entry,
    input  logic                                pop,
    output logic                                valid,
    output bbem_pkg::entry_t                    head,
    output logic [bbem_pkg::QUEUE_LEVEL_W-1:0]  level
);

    bbem_pkg::entry_t                        q_mem [bbem_pkg::QUEUE_DEPTH];
    logic [bbem_pkg::QUEUE_PTR_W-1:0]        wr_ptr_reg;
    logic [bbem_pkg::QUEUE_PTR_W-1:0]        rd_ptr_reg;
    logic [bbem_pkg::QUEUE_LEVEL_W-1:0]      count_reg;
    logic [bbem_pkg::QUEUE_LEVEL_W-1:0]      count_next;

    function automatic logic [bbem_pkg::QUEUE_PTR_W-1:0] ptr_inc(
        input logic [bbem_pkg::QUEUE_PTR_W-1:0] p
    );
        if (32'(p) == bbem_pkg::QUEUE_DEPTH - 1)
            return '0;
        return p + bbem_pkg::QUEUE_PTR_W'(1);
    endfunction

    assign valid = (count_reg != '0);
    assign head  = q_mem[rd_ptr_reg];
    assign level = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + bbem_pkg::QUEUE_LEVEL_W'(1);
        else if (pop && !push)
            count_next = count_reg - bbem_pkg::QUEUE_LEVEL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (32'(count_reg) == bbem_pkg::QUEUE_DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && (count_reg == '0)))
        else $error("queue underflow");

    a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + bbem_pkg::QUEUE_LEVEL_W'(1)))
        else $error("queue level lost a push");
`endif

endmodule

/* design/bbem_back.sv */
// Back end: 3x3 column window, neighbor sums, mean by reciprocal and output register.
`timescale 1ns / 1ps

module bbem_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  bbem_pkg::entry_t              q_head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bbem_pkg::PIX_W-1:0]    m_tdata,
    output logic                          m_tlast
);

    localparam logic [13:0] RECIP_6     = 14'd10923;
    localparam logic [13:0] RECIP_9     = 14'd7282;
    localparam int          RECIP_SHIFT = 16;
    localparam int          PROD_W      = bbem_pkg::SUM_W + 14;

    bbem_pkg::column_t                  left_reg;
    bbem_pkg::column_t                  cen_reg;

    logic                               out_ready;
    logic                               s_ready;
    logic                               emit;

    logic [bbem_pkg::SUM_W-1:0]         sum [bbem_pkg::NUM_COLOR];
    bbem_pkg::div_sel_t                 div_sel;

    logic                               s_valid_reg;
    logic [bbem_pkg::SUM_W-1:0]         s_sum_reg [bbem_pkg::NUM_COLOR];
    bbem_pkg::div_sel_t                 s_div_reg;
    logic [7:0]                         s_alpha_reg;
    logic                               s_last_reg;

    logic                               m_valid_reg;
    bbem_pkg::pixel_t                   m_data_reg;
    logic                               m_last_reg;
    bbem_pkg::pixel_t                   mean_px;

    function automatic logic [bbem_pkg::SUM_W-1:0] col_sum(
        input bbem_pkg::column_t c,
        input int                ch,
        input logic              use_top,
        input logic              use_bottom
    );
        logic [bbem_pkg::SUM_W-1:0] s;
        s = bbem_pkg::SUM_W'(c.mid[ch]);
        if (use_top)
            s = s + bbem_pkg::SUM_W'(c.top[ch]);
        if (use_bottom)
            s = s + bbem_pkg::SUM_W'(c.bot[ch]);
        return s;
    endfunction

    // Truncated quotient by 4, 6 or 9; the reciprocal is exact over the sum range
    function automatic logic [7:0] mean_of(
        input logic [bbem_pkg::SUM_W-1:0] s,
        input bbem_pkg::div_sel_t         d
    );
        logic [PROD_W-1:0] prod;
        prod = '0;
        case (d)
            bbem_pkg::DIV_BY_4: prod = PROD_W'(s) << (RECIP_SHIFT - 2);
            bbem_pkg::DIV_BY_6: prod = PROD_W'(s) * PROD_W'(RECIP_6);
            bbem_pkg::DIV_BY_9: prod = PROD_W'(s) * PROD_W'(RECIP_9);
            default:            prod = PROD_W'(s) << (RECIP_SHIFT - 2);
        endcase
        return 8'(prod >> RECIP_SHIFT);
    endfunction

    assign out_ready = !m_valid_reg || m_tready;
    assign s_ready   = !s_valid_reg || out_ready;
    assign pop       = q_valid && s_ready;
    assign emit      = pop && q_head.flags.emit;

    // Left is the older window column, centre the newer; the entry is the right column
    always_comb
    begin
        for (int ch = 0; ch < bbem_pkg::NUM_COLOR; ch++)
        begin
            sum[ch] = col_sum(cen_reg, ch, q_head.flags.use_top, q_head.flags.use_bottom);
            if (q_head.flags.use_left)
                sum[ch] = sum[ch] + col_sum(left_reg, ch, q_head.flags.use_top,
                                            q_head.flags.use_bottom);
            if (q_head.flags.use_right)
                sum[ch] = sum[ch] + col_sum(q_head.column, ch, q_head.flags.use_top,
                                            q_head.flags.use_bottom);
        end

        if ((q_head.flags.use_left && q_head.flags.use_right) &&
            (q_head.flags.use_top && q_head.flags.use_bottom))
            div_sel = bbem_pkg::DIV_BY_9;
        else if ((q_head.flags.use_left && q_head.flags.use_right) ||
                 (q_head.flags.use_top && q_head.flags.use_bottom))
            div_sel = bbem_pkg::DIV_BY_6;
        else
            div_sel = bbem_pkg::DIV_BY_4;
    end

    always_comb
    begin
        for (int ch = 0; ch < bbem_pkg::NUM_COLOR; ch++)
            mean_px[ch] = mean_of(s_sum_reg[ch], s_div_reg);
        mean_px[bbem_pkg::CH_ALPHA] = s_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_ready)
                s_valid_reg <= emit;
            if (out_ready)
                m_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            left_reg <= cen_reg;
            cen_reg  <= q_head.column;
        end
        if (emit)
        begin
            s_sum_reg   <= sum;
            s_div_reg   <= div_sel;
            s_alpha_reg <= cen_reg.mid[bbem_pkg::CH_ALPHA];
            s_last_reg  <= q_head.flags.last;
        end
        if (s_valid_reg && out_ready)
        begin
            m_data_reg <= mean_px;
            m_last_reg <= s_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* sim/box_blur_3x3_edge_mean_tb.sv */
// Self-checking testbench for the 3x3 edge-mean box blur stream block.
`timescale 1ns / 1ps

module box_blur_3x3_edge_mean_tb;

    // One expected output word: RGBA pixel plus the end-of-frame flag
    typedef struct packed {
        bbem_pkg::pixel_t px;
        logic             last;
    } blur_out_t;

    // Clock, reset and every block input start at a known value
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    // in_red[7:0], in_green[15:8], in_blue[23:16], in_alpha[31:24]
    logic [bbem_pkg::PIX_W-1:0]     s_tdata   = '0;
    // command[0]: 0 pixel, 1 drain
    logic [0:0]                     s_tuser   = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    logic [bbem_pkg::PIX_W-1:0]     m_tdata;
    // last_in_frame
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [bbem_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bbem_pkg::CFG_W-1:0]     cfg_data  = '0;

    // Percent of cycles in which each side idles
    int unsigned sender_idle   = 0;
    int unsigned receiver_idle = 0;
    int unsigned mismatches    = 0;
    int unsigned words_sent    = 0;

    // Blurred pixels predicted but not yet seen on the master side
    blur_out_t blur_q [$];

    // Predictor state: registers, both line stores, window and raster position
    logic [bbem_pkg::CFG_W-1:0] reg_width;
    logic [bbem_pkg::CFG_W-1:0] reg_height;
    bbem_pkg::pixel_t           line_above     [bbem_pkg::DEF_MAX_WIDTH];
    bbem_pkg::pixel_t           line_two_above [bbem_pkg::DEF_MAX_WIDTH];
    bbem_pkg::pixel_t           win            [3][3];  // [column][row], row 0 on top
    int unsigned                pos_row;
    int unsigned                pos_col;
    int unsigned                emitted;

    string ch_name [4] = '{"red", "green", "blue", "alpha"};

    box_blur_3x3_edge_mean dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Register values outside 2..max are kept but used clamped
    function automatic int unsigned clamp_dim(logic [bbem_pkg::CFG_W-1:0] v,
                                              int unsigned maxv);
        int unsigned x;
        x = v;
        if (x < 2)
            x = 2;
        if (x > maxv)
            x = maxv;
        return x;
    endfunction

    function automatic void restart_frame();
        pos_row = 0;
        pos_col = 0;
        emitted = 0;
    endfunction

    function automatic void model_reset();
        reg_width  = bbem_pkg::CFG_RESET;
        reg_height = bbem_pkg::CFG_RESET;
        for (int i = 0; i < bbem_pkg::DEF_MAX_WIDTH; i++)
        begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                win[c][r] = '0;
        restart_frame();
    endfunction

    // Mean of the in-frame neighbors around window column cc; the centre is
    // output pixel (orow, ocol). The frame's final pixel restarts the raster.
    function automatic blur_out_t window_mean(int cc, int unsigned orow, int unsigned ocol,
                                              int unsigned w, int unsigned h);
        blur_out_t   res;
        int unsigned sum [3];
        int unsigned cnt;
        int          col;
        for (int ch = 0; ch < bbem_pkg::NUM_COLOR; ch++)
            sum[ch] = 0;
        cnt = 0;
        for (int dc = -1; dc <= 1; dc++)
        begin
            col = cc + dc;
            if (col >= 0 && col <= 2 && !(dc < 0 && ocol == 0) && !(dc > 0 && ocol + 1 >= w))
            begin
                for (int dr = -1; dr <= 1; dr++)
                begin
                    if (!(dr < 0 && orow == 0) && !(dr > 0 && orow + 1 >= h))
                    begin
                        for (int ch = 0; ch < bbem_pkg::NUM_COLOR; ch++)
                            sum[ch] += win[col][1 + dr][ch];
                        cnt++;
                    end
                end
            end
        end
        if (cnt == 0)
            cnt = 1;
        for (int ch = 0; ch < bbem_pkg::NUM_COLOR; ch++)
            res.px[ch] = 8'(sum[ch] / cnt);
        res.px[bbem_pkg::CH_ALPHA] = win[cc][1][bbem_pkg::CH_ALPHA];
        emitted = (emitted + 1) & 32'hFFFFF;
        res.last = (orow + 1 == h) && (ocol + 1 == w);
        if (res.last)
            restart_frame();
        return res;
    endfunction

    // Advance the predictor by one accepted word and queue what it yields
    task automatic predict_word(logic cmd, bbem_pkg::pixel_t data);
        int unsigned      w;
        int unsigned      h;
        int unsigned      ir;
        int unsigned      ic;
        logic             draining;
        logic             produced;
        bbem_pkg::pixel_t pix;
        bbem_pkg::pixel_t top;
        bbem_pkg::pixel_t mid;
        w = clamp_dim(reg_width, bbem_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(reg_height, bbem_pkg::DEF_MAX_HEIGHT);
        ir = pos_row;
        ic = pos_col;
        draining = (ir >= h);
        produced = 1'b0;
        // A drain inside the frame is dropped without a trace
        if (cmd && !draining)
            return;
        if (ic >= w)
            ic = 0;
        // Past the last row every word flushes, whatever it carries
        pix = draining ? bbem_pkg::pixel_t'(0) : data;
        // At a row start the previous row's last column is still owed
        if (ic == 0 && ir >= 2)
        begin
            blur_q.push_back(window_mean(2, ir - 2, w - 1, w, h));
            produced = 1'b1;
        end
        top = line_two_above[ic];
        mid = line_above[ic];
        line_two_above[ic] = mid;
        line_above[ic]     = pix;
        for (int r = 0; r < 3; r++)
        begin
            win[0][r] = win[1][r];
            win[1][r] = win[2][r];
        end
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = pix;
        if (ic >= 1 && ir >= 1)
        begin
            blur_q.push_back(window_mean(1, ir - 1, ic - 1, w, h));
            produced = 1'b1;
        end
        // Frame just closed: hold the fresh start position
        if (produced && pos_row == 0 && pos_col == 0 && emitted == 0)
            return;
        ic++;
        if (ic >= w)
        begin
            ic = 0;
            ir++;
        end
        pos_row = ir;
        pos_col = ic;
    endtask

    // ------------------------------------------------------------------
    // Driving side: everything changes at the falling edge
    // ------------------------------------------------------------------

    // Offer one word, idle first at random, and return at the falling edge
    // after the handshake. Valid is never lowered and raised in one step.
    task automatic send_word(logic cmd, bbem_pkg::pixel_t data);
        while ($urandom_range(99) < sender_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_word(cmd, data);
        words_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every owed pixel, then let words that yield
    // nothing work through the line store, queue and two pipeline stages
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (blur_q.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // Write width then height on back-to-back cycles; each write restarts
    task automatic configure(logic [bbem_pkg::CFG_W-1:0] w, logic [bbem_pkg::CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= bbem_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        reg_width = w;
        restart_frame();
        @(negedge clk);
        cfg_index <= bbem_pkg::REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        reg_height = h;
        restart_frame();
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // One frame of random pixels at the current geometry, then width+1
    // flush words. With noise: stray drains inside the frame, pixels used
    // as flush words, a stray drain after the frame, and frames cut short.
    task automatic send_frame(logic noisy, output logic complete);
        int unsigned w;
        int unsigned h;
        int unsigned cut;
        w = clamp_dim(reg_width, bbem_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(reg_height, bbem_pkg::DEF_MAX_HEIGHT);
        cut = w * h;
        if (noisy && $urandom_range(9) == 0)
            cut = $urandom_range(w * h - 1, 1);
        for (int unsigned i = 0; i < cut; i++)
        begin
            if (noisy && $urandom_range(19) == 0)
                send_word(1'b1, $urandom());
            send_word(1'b0, $urandom());
        end
        complete = (cut == w * h);
        if (!complete)
            return;
        for (int unsigned i = 0; i <= w; i++)
            send_word((noisy && $urandom_range(3) == 0) ? 1'b0 : 1'b1, $urandom());
        if (noisy && $urandom_range(9) == 0)
            send_word(1'b1, $urandom());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frame: all four outputs are corners; extreme channel values,
    // a drain inside the frame, a pixel as a flush word, a drain after it
    task automatic test_corner_frame();
        wait_idle();
        configure(11'd2, 11'd2);
        send_word(1'b0, 32'hFFFF_FFFF);
        send_word(1'b0, 32'h0000_0000);
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b0, 32'h00FF_00FF);
        send_word(1'b0, 32'hFF00_FF00);
        send_word(1'b1, 32'h0000_0000);
        send_word(1'b0, 32'hA5A5_A5A5);
        send_word(1'b1, 32'h0000_0000);
        send_word(1'b1, 32'hFFFF_FFFF);
    endtask

    // Abandon a 3x3 frame halfway, restart it by a write, then run it whole
    // so the centre pixel takes the nine-neighbor mean
    task automatic test_restart_interior();
        logic done;
        wait_idle();
        configure(11'd3, 11'd3);
        repeat (5) send_word(1'b0, $urandom());
        wait_idle();
        configure(11'd3, 11'd3);
        send_frame(1'b0, done);
    endtask

    // Widest and tallest geometry, both reached through clamping; each frame
    // is cut short and dropped by the next write
    task automatic test_large_frames();
        wait_idle();
        configure(11'd2047, 11'd2);
        repeat (24) send_word(1'b0, $urandom());
        wait_idle();
        configure(11'd2, 11'd2047);
        repeat (60) send_word(1'b0, $urandom());
    endtask

    // Mostly whole frames of small random geometry, some below the clamp
    task automatic test_random_frames(int unsigned n_words);
        int unsigned                stop_at;
        logic                       need_cfg;
        logic                       done;
        logic [bbem_pkg::CFG_W-1:0] w_raw;
        logic [bbem_pkg::CFG_W-1:0] h_raw;
        stop_at  = words_sent + n_words;
        need_cfg = 1'b1;
        while (words_sent < stop_at)
        begin
            if (need_cfg || $urandom_range(2) == 0)
            begin
                w_raw = ($urandom_range(7) == 0) ? bbem_pkg::CFG_W'($urandom_range(1))
                                                 : bbem_pkg::CFG_W'($urandom_range(9, 2));
                h_raw = ($urandom_range(7) == 0) ? bbem_pkg::CFG_W'($urandom_range(1))
                                                 : bbem_pkg::CFG_W'($urandom_range(6, 2));
                wait_idle();
                configure(w_raw, h_raw);
            end
            send_frame(1'b1, done);
            // A cut frame leaves pending pixels behind; a write drops them
            need_cfg = !done;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiving side: back pressure and checking
    // ------------------------------------------------------------------

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= receiver_idle);

    task automatic report_mismatch(string what);
        mismatches++;
        $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    blur_out_t        want_px;
    bbem_pkg::pixel_t got_px;

    // Compare each accepted word field by field with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (blur_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word data=%08h last=%0b",
                                          m_tdata, m_tlast));
            end
            else
            begin
                want_px = blur_q.pop_front();
                got_px  = m_tdata;
                for (int ch = 0; ch < 4; ch++)
                    if (got_px[ch] !== want_px.px[ch])
                        report_mismatch($sformatf("%s got %02h want %02h", ch_name[ch],
                                                  got_px[ch], want_px.px[ch]));
                if (m_tlast !== want_px.last)
                    report_mismatch($sformatf("last_in_frame got %0b want %0b",
                                              m_tlast, want_px.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        model_reset();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Light sender gaps against a receiver that stalls most cycles
        sender_idle   = 16;
        receiver_idle = 70;
        test_corner_frame();
        test_restart_interior();
        test_large_frames();
        test_random_frames(115);

        // The other way round
        sender_idle   = 70;
        receiver_idle = 16;
        test_random_frames(115);

        // Full rate on both sides
        sender_idle   = 0;
        receiver_idle = 0;
        test_random_frames(115);

        wait_idle();
        if (blur_q.size() == 0 && mismatches == 0)
            $display("** box_blur_3x3_edge_mean: PASSED **");
        else
            $display("** box_blur_3x3_edge_mean: FAILED **");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run
    initial
    begin
        #3000000;
        $display("** box_blur_3x3_edge_mean: FAILED **");
        $finish;
    end

endmodule
